[hdl/bqcc_pkg.sv]
// ----------------------------------------------------------------------------
// bqcc_pkg
// Shared types, character codes and the per-byte judge function of the
// bracket / quote / comment checker.
// ----------------------------------------------------------------------------
package bqcc_pkg;

  // Counter widths
  localparam int unsigned DEPTH_BITS  = 8;
  localparam int unsigned ESCAPE_BITS = 16;

  localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = '1;
  localparam logic [ESCAPE_BITS-1:0] ESCAPE_MAX = '1;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LC_N   = 8'h6E;

  // Error codes
  typedef enum logic [1:0] {
    PERR_NONE         = 2'd0,
    PERR_OPEN_EXCESS  = 2'd1,
    PERR_CLOSE_EXCESS = 2'd2,
    PERR_OPEN_LEFT    = 2'd3
  } perr_e;

  typedef enum logic [1:0] {
    BERR_NONE         = 2'd0,
    BERR_NESTED       = 2'd1,
    BERR_CLOSE_EXCESS = 2'd2,
    BERR_OPEN_LEFT    = 2'd3
  } berr_e;

  // Scanner state
  typedef struct packed {
    logic [7:0]             held_char;
    logic                   held_valid;
    logic [7:0]             prev_char;
    logic                   in_quote;
    logic [7:0]             quote_kind;
    logic                   in_block;
    logic                   in_line;
    logic [DEPTH_BITS-1:0]  paren_depth;
    logic                   bracket_depth;
    logic [DEPTH_BITS-1:0]  brace_depth;
    logic [ESCAPE_BITS-1:0] escape_total;
  } state_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  out_char;
    logic [1:0]  paren_error;
    logic [7:0]  paren_open_count;
    logic [1:0]  bracket_error;
    logic        brace_excess_close;
    logic        is_final;
    logic [7:0]  unclosed_braces;
    logic [15:0] newline_escape_count;
    logic        quote_unclosed;
  } result_t;

  typedef struct packed {
    state_t  st;
    result_t res;
  } judge_t;

  function automatic logic [7:0] sat_depth8(logic [DEPTH_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    sat_depth8 = (w > 32'd255) ? 8'hFF : 8'(w);
  endfunction

  function automatic logic [15:0] sat_escape16(logic [ESCAPE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    sat_escape16 = (w > 32'd65535) ? 16'hFFFF : 16'(w);
  endfunction

  // Judge the held byte against its lookahead and update the scanner state
  function automatic judge_t judge(state_t s, logic has_next, logic [7:0] nx, logic fin);
    judge_t     j;
    logic [7:0] b;
    logic [7:0] p;
    logic       nslash;
    logic       nstar;
    logic       active;
    perr_e      perr;
    berr_e      berr;
    logic [7:0] pcnt;
    logic       bxc;
    j      = '0;
    j.st   = s;
    b      = s.held_char;
    p      = s.prev_char;
    nslash = has_next && (nx == CH_SLASH);
    nstar  = has_next && (nx == CH_STAR);
    perr   = PERR_NONE;
    berr   = BERR_NONE;
    pcnt   = 8'd0;
    bxc    = 1'b0;

    // quotes
    if (j.st.in_quote && b == j.st.quote_kind) begin
      j.st.in_quote = 1'b0;
    end else if ((b == CH_DQUOTE || b == CH_SQUOTE) && p != CH_BSLASH &&
                 !j.st.in_quote && !j.st.in_block && !j.st.in_line) begin
      j.st.in_quote   = 1'b1;
      j.st.quote_kind = b;
    end

    // block comment
    if (b == CH_SLASH && nstar && !j.st.in_quote && !j.st.in_block && !j.st.in_line) begin
      j.st.in_block = 1'b1;
    end else if (b == CH_STAR && nslash && j.st.in_block) begin
      j.st.in_block = 1'b0;
    end

    // line comment
    if (b == CH_SLASH && nslash && !j.st.in_quote && !j.st.in_block && !j.st.in_line) begin
      j.st.in_line = 1'b1;
    end else if (b == CH_NL && j.st.in_line) begin
      j.st.in_line = 1'b0;
    end

    active = !j.st.in_quote && !j.st.in_block && !j.st.in_line;

    // parentheses
    if (active && b == CH_LPAREN) begin
      if (j.st.paren_depth != DEPTH_MAX) j.st.paren_depth = j.st.paren_depth + 1'b1;
    end else if (active && b == CH_RPAREN) begin
      if (j.st.paren_depth == '0) perr = PERR_CLOSE_EXCESS;
      else j.st.paren_depth = j.st.paren_depth - 1'b1;
    end
    if (perr == PERR_NONE && b == CH_NL) begin
      if (j.st.paren_depth > DEPTH_BITS'(1)) begin
        perr = PERR_OPEN_EXCESS;
        pcnt = sat_depth8(j.st.paren_depth);
      end else if (j.st.paren_depth != '0) begin
        perr = PERR_OPEN_LEFT;
      end
      j.st.paren_depth = '0;
    end

    // brackets, one level deep
    if (active && b == CH_LBRACK) begin
      if (j.st.bracket_depth) berr = BERR_NESTED;
      else j.st.bracket_depth = 1'b1;
    end else if (active && b == CH_RBRACK) begin
      if (!j.st.bracket_depth) berr = BERR_CLOSE_EXCESS;
      else j.st.bracket_depth = 1'b0;
    end
    if (berr == BERR_NONE && b == CH_NL && j.st.bracket_depth) begin
      berr = BERR_OPEN_LEFT;
      j.st.bracket_depth = 1'b0;
    end

    // braces
    if (active && b == CH_LBRACE) begin
      if (j.st.brace_depth != DEPTH_MAX) j.st.brace_depth = j.st.brace_depth + 1'b1;
    end else if (active && b == CH_RBRACE) begin
      if (j.st.brace_depth == '0) bxc = 1'b1;
      else j.st.brace_depth = j.st.brace_depth - 1'b1;
    end

    // backslash-n outside quotes and comments
    if (active && b == CH_LC_N && p == CH_BSLASH && j.st.escape_total != ESCAPE_MAX) begin
      j.st.escape_total = j.st.escape_total + 1'b1;
    end

    j.st.prev_char = b;

    j.res.out_char           = b;
    j.res.paren_error        = perr;
    j.res.paren_open_count   = pcnt;
    j.res.bracket_error      = berr;
    j.res.brace_excess_close = bxc;
    j.res.is_final           = fin;
    j.res.unclosed_braces    = fin ? sat_depth8(j.st.brace_depth) : 8'd0;
    j.res.newline_escape_count = fin ? sat_escape16(j.st.escape_total) : 16'd0;
    j.res.quote_unclosed     = fin && j.st.in_quote;
    return j;
  endfunction

endpackage

[hdl/bqcc_if.sv]
// ----------------------------------------------------------------------------
// bqcc_if
// Valid/ready channels of the checker: source bytes in, judged bytes out.
// ----------------------------------------------------------------------------
interface bqcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface bqcc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic [1:0]  paren_error;
  logic [7:0]  paren_open_count;
  logic [1:0]  bracket_error;
  logic        brace_excess_close;
  logic        is_final;
  logic [7:0]  unclosed_braces;
  logic [15:0] newline_escape_count;
  logic        quote_unclosed;

  modport source (output valid, output out_char, output paren_error,
                  output paren_open_count, output bracket_error,
                  output brace_excess_close, output is_final,
                  output unclosed_braces, output newline_escape_count,
                  output quote_unclosed, input ready);
  modport sink   (input valid, input out_char, input paren_error,
                  input paren_open_count, input bracket_error,
                  input brace_excess_close, input is_final,
                  input unclosed_braces, input newline_escape_count,
                  input quote_unclosed, output ready);
endinterface

[hdl/bracket_quote_comment_checker_top.sv]
// Results: a byte's result enters the output register when the byte that
//   follows it is accepted; the final byte's result enters it once the
//   output register is free, and the input is stalled until then.
// Throughput: one byte per cycle while the output is not stalled and no
//   final byte is pending, bounded by the single output result register.
// Reset: asynchronous, clears all scanner state and the output valid.
// ----------------------------------------------------------------------------
// bracket_quote_comment_checker_top
// Scans C source bytes with one byte of lookahead, reports bracket, paren
// and brace errors per byte and a final summary of braces, quote, escapes.
// ----------------------------------------------------------------------------
module bracket_quote_comment_checker_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  bqcc_in_if.sink           in_i,
  bqcc_out_if.source        out_o
);

  bqcc_pkg::state_t  st_q, st_d;
  bqcc_pkg::result_t res_q, res_d;
  bqcc_pkg::judge_t  jdg;
  logic              final_pend_q, final_pend_d;
  logic              out_valid_q, out_valid_d;
  logic              can_emit;
  logic              acc_in;
  logic              fire_next;
  logic              fire_final;

  // Output slot is free or drains this cycle
  assign can_emit   = !out_valid_q || out_o.ready;
  assign in_i.ready = !final_pend_q && can_emit;
  assign acc_in     = in_i.valid && in_i.ready;
  assign fire_next  = acc_in && st_q.held_valid;
  assign fire_final = final_pend_q && can_emit;

  // Judge the held byte
  assign jdg = bqcc_pkg::judge(st_q, !final_pend_q, in_i.in_char, final_pend_q);

  // Advance scanner state
  always_comb begin
    st_d         = st_q;
    final_pend_d = final_pend_q;
    if (fire_final) begin
      st_d         = '0;
      final_pend_d = 1'b0;
    end else if (acc_in) begin
      if (st_q.held_valid) st_d = jdg.st;
      st_d.held_char  = in_i.in_char;
      st_d.held_valid = 1'b1;
      final_pend_d    = in_i.in_last;
    end
  end

  // Load or hold the result register
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (fire_next || fire_final) begin
      res_d       = jdg.res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      final_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      final_pend_q <= final_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Drive the result beat
  assign out_o.valid                = out_valid_q;
  assign out_o.out_char             = res_q.out_char;
  assign out_o.paren_error          = res_q.paren_error;
  assign out_o.paren_open_count     = res_q.paren_open_count;
  assign out_o.bracket_error        = res_q.bracket_error;
  assign out_o.brace_excess_close   = res_q.brace_excess_close;
  assign out_o.is_final             = res_q.is_final;
  assign out_o.unclosed_braces      = res_q.unclosed_braces;
  assign out_o.newline_escape_count = res_q.newline_escape_count;
  assign out_o.quote_unclosed       = res_q.quote_unclosed;

`ifndef SYNTHESIS
  // Final byte pending always stalls the input
  a_final_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_pend_q |-> !in_i.ready)
    else $error("input accepted while final byte pending");

  // Final result clears the held byte
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_final |=> (!st_q.held_valid && !final_pend_q && out_valid_q && res_q.is_final))
    else $error("final result did not restart the scanner");

  // Summary fields only on final beats
  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.is_final) |->
      (res_q.unclosed_braces == 8'd0 && res_q.newline_escape_count == 16'd0 &&
       !res_q.quote_unclosed))
    else $error("summary fields set on non-final beat");

  // Paren count only with excess-open error
  a_pcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.paren_error != bqcc_pkg::PERR_OPEN_EXCESS) |->
      res_q.paren_open_count == 8'd0)
    else $error("paren count without excess open error");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed");
`endif

endmodule

[sim/tb_bracket_quote_comment_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_quote_comment_checker_top
// Drives C-like texts byte by byte into the checker. A scanner model in the
// bench predicts every judged byte. Each result beat is compared field by
// field in arrival order. The run covers directed error cases, depth counter
// saturation, random texts under three idle mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb_bracket_quote_comment_checker_top;

  localparam int    CYCLE_LIMIT     = 200000;
  localparam int    PRINT_LIMIT     = 40;
  localparam int    BYTES_PER_MIX   = 230;
  localparam string SPECIAL_CHARS   = "()[]{}\n\\/*\"'n";
  localparam string PLAIN_CHARS     = "abnx_ =;0";

  // Scanner state of the bench model
  typedef struct packed {
    bit [7:0]                       held;
    bit                             held_ok;
    bit [7:0]                       prev;
    bit                             quoted;
    bit [7:0]                       quote_ch;
    bit                             in_block;
    bit                             in_line;
    bit [bqcc_pkg::DEPTH_BITS-1:0]  parens;
    bit                             bracket_open;
    bit [bqcc_pkg::DEPTH_BITS-1:0]  braces;
    bit [bqcc_pkg::ESCAPE_BITS-1:0] escapes;
  } scan_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bqcc_in_if  in_if ();
  bqcc_out_if out_if ();

  bracket_quote_comment_checker_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  scan_t              scan;
  bqcc_pkg::result_t  pending_reports[$];
  bit [7:0]           text_bytes[$];
  bqcc_pkg::result_t  want;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_off_req   = 0;
  int hold_left      = 0;
  int mismatches     = 0;
  int beats_checked  = 0;
  int finals_checked = 0;
  int bytes_sent     = 0;
  int texts_sent     = 0;
  int cycle_count    = 0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Judge one byte against its lookahead and advance the scanner model
  function automatic bqcc_pkg::result_t judge_byte(bit [7:0] b, bit has_next,
                                                   bit [7:0] nx, bit fin);
    bqcc_pkg::result_t r;
    bit [7:0]          p;
    bit                may_open;
    bit                live;
    bqcc_pkg::perr_e   pe;
    bqcc_pkg::berr_e   be;
    r  = '0;
    p  = scan.prev;
    pe = bqcc_pkg::PERR_NONE;
    be = bqcc_pkg::BERR_NONE;

    // close a quote on its own kind, open one only outside quotes and comments
    if (scan.quoted && b == scan.quote_ch) begin
      scan.quoted = 1'b0;
    end else if ((b == bqcc_pkg::CH_DQUOTE || b == bqcc_pkg::CH_SQUOTE) &&
                 p != bqcc_pkg::CH_BSLASH && !scan.quoted &&
                 !scan.in_block && !scan.in_line) begin
      scan.quoted   = 1'b1;
      scan.quote_ch = b;
    end

    // comments open only in plain code, after the quote update
    may_open = !scan.quoted && !scan.in_block && !scan.in_line;
    if (b == bqcc_pkg::CH_SLASH && has_next && nx == bqcc_pkg::CH_STAR && may_open) begin
      scan.in_block = 1'b1;
    end else if (b == bqcc_pkg::CH_STAR && has_next && nx == bqcc_pkg::CH_SLASH &&
                 scan.in_block) begin
      scan.in_block = 1'b0;
    end
    if (b == bqcc_pkg::CH_SLASH && has_next && nx == bqcc_pkg::CH_SLASH && may_open) begin
      scan.in_line = 1'b1;
    end else if (b == bqcc_pkg::CH_NL && scan.in_line) begin
      scan.in_line = 1'b0;
    end

    live = !scan.quoted && !scan.in_block && !scan.in_line;

    // parens: newline rule holds everywhere, also in quotes and comments
    if (live && b == bqcc_pkg::CH_LPAREN) begin
      if (scan.parens != '1) scan.parens++;
    end else if (live && b == bqcc_pkg::CH_RPAREN) begin
      if (scan.parens == 0) pe = bqcc_pkg::PERR_CLOSE_EXCESS;
      else scan.parens--;
    end
    if (pe == bqcc_pkg::PERR_NONE && b == bqcc_pkg::CH_NL) begin
      if (scan.parens > 1) begin
        pe = bqcc_pkg::PERR_OPEN_EXCESS;
        r.paren_open_count = (32'(scan.parens) > 32'd255) ? 8'hFF : 8'(scan.parens);
      end else if (scan.parens != 0) begin
        pe = bqcc_pkg::PERR_OPEN_LEFT;
      end
      scan.parens = '0;
    end

    // brackets never nest
    if (live && b == bqcc_pkg::CH_LBRACK) begin
      if (scan.bracket_open) be = bqcc_pkg::BERR_NESTED;
      else scan.bracket_open = 1'b1;
    end else if (live && b == bqcc_pkg::CH_RBRACK) begin
      if (!scan.bracket_open) be = bqcc_pkg::BERR_CLOSE_EXCESS;
      else scan.bracket_open = 1'b0;
    end
    if (be == bqcc_pkg::BERR_NONE && b == bqcc_pkg::CH_NL && scan.bracket_open) begin
      be = bqcc_pkg::BERR_OPEN_LEFT;
      scan.bracket_open = 1'b0;
    end

    // braces carry over lines
    if (live && b == bqcc_pkg::CH_LBRACE) begin
      if (scan.braces != '1) scan.braces++;
    end else if (live && b == bqcc_pkg::CH_RBRACE) begin
      if (scan.braces == 0) r.brace_excess_close = 1'b1;
      else scan.braces--;
    end

    // count backslash-n in plain code
    if (live && b == bqcc_pkg::CH_LC_N && p == bqcc_pkg::CH_BSLASH &&
        scan.escapes != '1) scan.escapes++;

    scan.prev       = b;
    r.out_char      = b;
    r.paren_error   = pe;
    r.bracket_error = be;
    r.is_final      = fin;
    if (fin) begin
      r.unclosed_braces      = (32'(scan.braces) > 32'd255) ? 8'hFF : 8'(scan.braces);
      r.newline_escape_count = (32'(scan.escapes) > 32'd65535) ? 16'hFFFF
                                                                 : 16'(scan.escapes);
      r.quote_unclosed       = scan.quoted;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp);
    if (got !== exp) begin
      report_mismatch($sformatf("%s got %0h expected %0h on byte %0h", name, got, exp,
                                want.out_char));
    end
  endtask

  // Receiver: random idling, or hold off for a requested stretch
  always @(posedge clk_i) begin
    if (hold_off_req > 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result beat for byte %0h with nothing pending",
                                  out_if.out_char));
      end else begin
        want = pending_reports.pop_front();
        beats_checked++;
        if (want.is_final) finals_checked++;
        check_field("out_char", 32'(out_if.out_char), 32'(want.out_char));
        check_field("paren_error", 32'(out_if.paren_error), 32'(want.paren_error));
        check_field("paren_open_count", 32'(out_if.paren_open_count),
                    32'(want.paren_open_count));
        check_field("bracket_error", 32'(out_if.bracket_error), 32'(want.bracket_error));
        check_field("brace_excess_close", 32'(out_if.brace_excess_close),
                    32'(want.brace_excess_close));
        check_field("is_final", 32'(out_if.is_final), 32'(want.is_final));
        check_field("unclosed_braces", 32'(out_if.unclosed_braces),
                    32'(want.unclosed_braces));
        check_field("newline_escape_count", 32'(out_if.newline_escape_count),
                    32'(want.newline_escape_count));
        check_field("quote_unclosed", 32'(out_if.quote_unclosed),
                    32'(want.quote_unclosed));
      end
    end
  end

  // Offer one byte, wait for its beat, then predict what it releases
  task automatic send_byte(bit [7:0] c, bit last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.in_char <= c;
    in_if.in_last <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (scan.held_ok) pending_reports.push_back(judge_byte(scan.held, 1'b1, c, 1'b0));
    scan.held    = c;
    scan.held_ok = 1'b1;
    if (last) begin
      pending_reports.push_back(judge_byte(c, 1'b0, 8'h00, 1'b1));
      scan = '0;
      texts_sent++;
    end
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
    text_bytes.delete();
  endtask

  // Drop valid and wait until every predicted beat has arrived
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic void queue_string(string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  // Append a short run of mixed bytes: specials, plain text, any byte
  function automatic void add_noise();
    int unsigned n;
    int unsigned sel;
    n = $urandom_range(6);
    repeat (n) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        text_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 5) begin
        text_bytes.push_back(SPECIAL_CHARS[$urandom_range(SPECIAL_CHARS.len() - 1)]);
      end else begin
        text_bytes.push_back(PLAIN_CHARS[$urandom_range(PLAIN_CHARS.len() - 1)]);
      end
    end
  endfunction

  // Build a text mostly of well-formed constructs with random bodies
  function automatic void build_random_text();
    int unsigned tokens;
    bit [7:0]    q;
    tokens = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
    repeat (tokens) begin
      case ($urandom_range(11))
        0: text_bytes.push_back(8'($urandom_range(255)));
        1: begin
          queue_string("/*");
          add_noise();
          queue_string("*/");
        end
        2: begin
          queue_string("//");
          add_noise();
          queue_string("\n");
        end
        3: begin
          q = $urandom_range(1) ? bqcc_pkg::CH_DQUOTE : bqcc_pkg::CH_SQUOTE;
          text_bytes.push_back(q);
          add_noise();
          text_bytes.push_back(q);
        end
        4: queue_string("\\n");
        5: begin
          queue_string("(");
          add_noise();
          queue_string(")");
        end
        6: begin
          queue_string("[");
          add_noise();
          queue_string("]");
        end
        7: begin
          queue_string("{");
          add_noise();
          queue_string("}");
        end
        8: queue_string("\n");
        9: text_bytes.push_back($urandom_range(1) ? bqcc_pkg::CH_LBRACE
                                                   : bqcc_pkg::CH_RBRACE);
        default: add_noise();
      endcase
    end
    if (text_bytes.size() == 0) text_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Every error code, quotes, both comment kinds, escapes, unclosed quote
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_string("((\n)[[]][\n}{\\n(\"\n\"/*)*/ //)\n'");
    text_bytes.push_back(8'hFF);
    send_text();
    // single-byte text: no lookahead at all
    text_bytes.push_back(8'h00);
    send_text();
    drain_results();
  endtask

  // Drive paren and brace depths past their limits
  task automatic test_counter_saturation();
    repeat (300) text_bytes.push_back(bqcc_pkg::CH_LPAREN);
    text_bytes.push_back(bqcc_pkg::CH_NL);
    repeat (300) text_bytes.push_back(bqcc_pkg::CH_LBRACE);
    send_text();
    drain_results();
  endtask

  // Random texts under three idle mixes
  task automatic test_random_texts();
    int send_mix[3] = '{23, 80, 0};
    int recv_mix[3] = '{80, 23, 0};
    int start_bytes;
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_mix[m];
      recv_idle_pct = recv_mix[m];
      start_bytes   = bytes_sent;
      while (bytes_sent - start_bytes < BYTES_PER_MIX) begin
        build_random_text();
        send_text();
      end
      drain_results();
    end
  endtask

  // Hold the output off long enough for the input to back up
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 200;
    while (text_bytes.size() < 60) build_random_text();
    send_text();
    drain_results();
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.in_char <= 8'h00;
    in_if.in_last <= 1'b0;
    scan = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_counter_saturation();
    test_random_texts();
    test_output_stall();

    // let any stray beat show up
    repeat (8) @(posedge clk_i);

    $display("tb: %0d texts, %0d bytes driven; %0d result beats checked, %0d final",
             texts_sent, bytes_sent, beats_checked, finals_checked);
    $display("tb: error codes, depth saturation, three idle mixes and a 200-cycle stall");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d beats missing", mismatches, pending_reports.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bqcc_pkg.sv
hdl/bqcc_if.sv
hdl/bracket_quote_comment_checker_top.sv
sim/tb_bracket_quote_comment_checker_top.sv
